[design/latcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latcf_pkg: shared types and constants for the lamp address table framer
// Opcode and status codes, stream field layout, frame constants.
// ----------------------------------------------------------------------------
package latcf_pkg;

    localparam int DEFAULT_MAX_LAMPS = 8;

    // one stored address: 4 lamp bytes above 5 remote bytes
    localparam int LAMP_ID_W   = 32;
    localparam int REMOTE_ID_W = 40;
    localparam int ADDR_W      = LAMP_ID_W + REMOTE_ID_W;

    localparam int OPCODE_W    = 3;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 7;
    localparam int S_TDATA_W   = 112;
    localparam int M_TDATA_W   = 104;

    // output tdata bit positions
    localparam int M_STATUS_LSB = 8;
    localparam int M_SLOT_LSB   = 11;
    localparam int M_COUNT_LSB  = 91;

    localparam int          FRAME_LEN    = 15;
    localparam int          FRAME_W      = FRAME_LEN * 8;
    localparam logic [7:0]  FRAME_HEADER = 8'h0E;
    localparam logic [7:0]  LEARN_TAIL   = 8'h11;
    localparam logic [7:0]  CMD_LEARN_A  = 8'h03;
    localparam logic [7:0]  CMD_LEARN_B  = 8'h05;
    localparam logic [7:0]  CMD_LEARN_C  = 8'h07;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LEARN = 3'd0,
        OP_ADD   = 3'd1,
        OP_READ  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_SEND  = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_DUP       = 3'd2,
        STAT_FILTERED  = 3'd3,
        STAT_BAD_INDEX = 3'd4
    } status_t;

endpackage

[design/lamp_address_table_command_framer.sv]
`timescale 1ns / 1ps
// Read, clear, spare opcodes, filtered learn and bad index put their result out from
// SQ_READ or SQ_STATUS after accept; add and learn on an empty table pass SQ_STORE first.
// Learn scans one stored entry per cycle through the RAM read port in SQ_SCAN.
// Send: SQ_LOAD builds the frame, then SQ_SEND puts out one byte per cycle unless stalled.
// One transaction at a time, s_axis_tready only when idle; output stalls hold the sequencer.
// Reset (aresetn low, synchronous): empty table, sequence number 0, no output pending.
// ----------------------------------------------------------------------------
// lamp_address_table_command_framer
// Table of learned lamp addresses in RAM with a fill count; sequencer that
// answers learn/add/read/clear and serializes 15-byte transmit frames.
// ----------------------------------------------------------------------------
module lamp_address_table_command_framer #(
    parameter int MAX_LAMPS = latcf_pkg::DEFAULT_MAX_LAMPS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // lamp_id[31:0], remote_id[71:32], slot_index[79:72], lamp_command[87:80],
    // hue[95:88], saturation[103:96], brightness[111:104]
    input  logic [latcf_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // opcode[2:0]
    input  logic [latcf_pkg::OPCODE_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // frame_byte[7:0], status[10:8], slot_out[18:11], lamp_id_out[50:19],
    // remote_id_out[90:51], lamp_count[97:91], zero pad [103:98]
    output logic [latcf_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // result_kind[0]
    output logic [0:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);
    import latcf_pkg::*;

    localparam int AW = (MAX_LAMPS > 1) ? $clog2(MAX_LAMPS) : 1;
    localparam int CW = $clog2(MAX_LAMPS + 1);

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_STATUS,
        SQ_SCAN,
        SQ_STORE,
        SQ_READ,
        SQ_LOAD,
        SQ_SEND
    } seq_state_t;

    seq_state_t          state_reg, state_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [7:0]          seq_reg, seq_next;
    logic [AW-1:0]       scan_reg, scan_next;
    logic [AW-1:0]       rd_addr_reg, rd_addr_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    status_t             status_reg, status_next;
    logic [7:0]          slot_reg, slot_next;

    // latched input transaction
    logic [ADDR_W-1:0]   key_reg, key_next;
    logic [7:0]          idx_reg, idx_next;
    logic [7:0]          cmd_reg, cmd_next;
    logic [23:0]         hsv_reg, hsv_next;

    // output register
    logic                ovalid_reg, ovalid_next;
    logic                okind_reg, okind_next;
    logic                olast_reg, olast_next;
    logic [7:0]          obyte_reg, obyte_next;
    logic [STATUS_W-1:0] ostat_reg, ostat_next;
    logic [7:0]          oslot_reg, oslot_next;
    logic [ADDR_W-1:0]   oaddr_reg, oaddr_next;
    logic [COUNT_W-1:0]  ocount_reg, ocount_next;

    logic                wr_en;
    logic [ADDR_W-1:0]   rd_data;
    logic                out_free;
    logic                in_accept;
    logic                slot_ok;
    logic                learn_pass;
    logic [7:0]          in_cmd;
    logic [7:0]          in_idx;
    opcode_t             in_op;

    latcf_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (MAX_LAMPS),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (key_reg),
        .rd_addr (rd_addr_next),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == SQ_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ovalid_reg || m_axis_tready;
    assign in_op         = opcode_t'(s_axis_tuser);
    assign in_idx        = s_axis_tdata[79:72];
    assign in_cmd        = s_axis_tdata[87:80];
    assign slot_ok       = in_idx < 8'(fill_reg);
    assign learn_pass    = (in_cmd == CMD_LEARN_A || in_cmd == CMD_LEARN_B ||
                            in_cmd == CMD_LEARN_C) && (s_axis_tdata[39:32] == LEARN_TAIL);

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        seq_next     = seq_reg;
        scan_next    = scan_reg;
        rd_addr_next = rd_addr_reg;
        cnt_next     = cnt_reg;
        frame_next   = frame_reg;
        status_next  = status_reg;
        slot_next    = slot_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        cmd_next     = cmd_reg;
        hsv_next     = hsv_reg;
        wr_en        = 1'b0;

        ovalid_next  = ovalid_reg && !m_axis_tready;
        okind_next   = okind_reg;
        olast_next   = olast_reg;
        obyte_next   = obyte_reg;
        ostat_next   = ostat_reg;
        oslot_next   = oslot_reg;
        oaddr_next   = oaddr_reg;
        ocount_next  = ocount_reg;

        unique case (state_reg)
            SQ_IDLE: begin
                if (in_accept) begin
                    // address key is {lamp_id, remote_id}
                    key_next    = {s_axis_tdata[31:0], s_axis_tdata[71:32]};
                    idx_next    = in_idx;
                    cmd_next    = in_cmd;
                    hsv_next    = {s_axis_tdata[95:88], s_axis_tdata[103:96],
                                   s_axis_tdata[111:104]};
                    status_next = STAT_OK;
                    slot_next   = 8'd0;
                    state_next  = SQ_STATUS;
                    unique case (in_op) inside
                        OP_LEARN: begin
                            if (!learn_pass) begin
                                status_next = STAT_FILTERED;
                            end else if (fill_reg == '0) begin
                                state_next = SQ_STORE;
                            end else begin
                                scan_next    = '0;
                                rd_addr_next = '0;
                                state_next   = SQ_SCAN;
                            end
                        end
                        OP_ADD: begin
                            state_next = SQ_STORE;
                        end
                        OP_READ, OP_SEND: begin
                            if (!slot_ok) begin
                                status_next = STAT_BAD_INDEX;
                            end else begin
                                rd_addr_next = in_idx[AW-1:0];
                                state_next   = (in_op == OP_READ) ? SQ_READ : SQ_LOAD;
                            end
                        end
                        OP_CLEAR: begin
                            fill_next = '0;
                        end
                        default: begin
                            state_next = SQ_STATUS;
                        end
                    endcase
                end
            end
            SQ_STATUS: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    okind_next  = 1'b0;
                    olast_next  = 1'b1;
                    obyte_next  = 8'd0;
                    ostat_next  = status_reg;
                    oslot_next  = slot_reg;
                    oaddr_next  = '0;
                    ocount_next = COUNT_W'(fill_reg);
                    state_next  = SQ_IDLE;
                end
            end
            SQ_SCAN: begin
                // rd_data holds entry scan_reg; read of the next entry is issued now
                if (rd_data == key_reg) begin
                    status_next = STAT_DUP;
                    state_next  = SQ_STATUS;
                end else if ((CW'(scan_reg) + CW'(1)) == fill_reg) begin
                    state_next = SQ_STORE;
                end else begin
                    scan_next    = scan_reg + AW'(1);
                    rd_addr_next = scan_reg + AW'(1);
                end
            end
            SQ_STORE: begin
                if (fill_reg == CW'(MAX_LAMPS)) begin
                    status_next = STAT_FULL;
                end else begin
                    wr_en     = 1'b1;
                    slot_next = 8'(fill_reg);
                    fill_next = fill_reg + CW'(1);
                end
                state_next = SQ_STATUS;
            end
            SQ_READ: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    okind_next  = 1'b0;
                    olast_next  = 1'b1;
                    obyte_next  = 8'd0;
                    ostat_next  = STAT_OK;
                    oslot_next  = idx_reg;
                    oaddr_next  = rd_data;
                    ocount_next = COUNT_W'(fill_reg);
                    state_next  = SQ_IDLE;
                end
            end
            SQ_LOAD: begin
                frame_next = {FRAME_HEADER, rd_data, cmd_reg, seq_reg, hsv_reg};
                seq_next   = seq_reg + 8'd1;
                cnt_next   = '0;
                state_next = SQ_SEND;
            end
            SQ_SEND: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    okind_next  = 1'b1;
                    olast_next  = (cnt_reg == 4'(FRAME_LEN - 1));
                    obyte_next  = frame_reg[FRAME_W-1 -: 8];
                    ostat_next  = STAT_OK;
                    oslot_next  = 8'd0;
                    oaddr_next  = '0;
                    ocount_next = COUNT_W'(fill_reg);
                    frame_next  = {frame_reg[FRAME_W-9:0], 8'd0};
                    cnt_next    = cnt_reg + 4'd1;
                    if (cnt_reg == 4'(FRAME_LEN - 1)) begin
                        state_next = SQ_IDLE;
                    end
                end
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= SQ_IDLE;
            fill_reg   <= '0;
            seq_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            seq_reg    <= seq_next;
            ovalid_reg <= ovalid_next;
        end
        scan_reg    <= scan_next;
        rd_addr_reg <= rd_addr_next;
        cnt_reg     <= cnt_next;
        frame_reg   <= frame_next;
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        key_reg     <= key_next;
        idx_reg     <= idx_next;
        cmd_reg     <= cmd_next;
        hsv_reg     <= hsv_next;
        okind_reg   <= okind_next;
        olast_reg   <= olast_next;
        obyte_reg   <= obyte_next;
        ostat_reg   <= ostat_next;
        oslot_reg   <= oslot_next;
        oaddr_reg   <= oaddr_next;
        ocount_reg  <= ocount_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {6'd0, ocount_reg, oaddr_reg[REMOTE_ID_W-1:0],
                            oaddr_reg[ADDR_W-1:REMOTE_ID_W], oslot_reg, ostat_reg, obyte_reg};

endmodule

[design/latcf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latcf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module latcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[design/latcf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latcf_checker: port-level assertions for the lamp address table framer
// Watches both stream channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module latcf_checker #(
    parameter int MAX_LAMPS = latcf_pkg::DEFAULT_MAX_LAMPS
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [latcf_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic [0:0]                       m_axis_tuser,
    input logic                             m_axis_tlast
);
    import latcf_pkg::*;

    logic [COUNT_W-1:0] count_out;
    assign count_out = m_axis_tdata[M_COUNT_LSB +: COUNT_W];

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // one transaction in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // status results are always single, hence last
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
        else $error("status result without tlast");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> count_out <= COUNT_W'(MAX_LAMPS))
        else $error("lamp count above table size");

    // nothing leaves the block right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind lamp_address_table_command_framer latcf_checker #(
    .MAX_LAMPS (MAX_LAMPS)
) u_latcf_checker (.*);
